/* design/nbe_pkg.sv */
// Shared types and constants of the backpropagation neuron element.
`default_nettype none

package nbe_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_INPUTS = 64;
  localparam int ADDR_W     = $clog2(MAX_INPUTS);
  localparam int Q30_DROP   = 30 - FRAC_BITS;
  localparam int MAG_W      = 46;
  localparam int TAYLOR_TERMS = 14;
  localparam int EXP_K_BITS = 5;

  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
  localparam logic [30:0] E_INV_Q30 = 31'd395007542;

  localparam logic [2:0] REQ_FWD    = 3'd0;
  localparam logic [2:0] REQ_TARGET = 3'd1;
  localparam logic [2:0] REQ_HIDDEN = 3'd2;
  localparam logic [2:0] REQ_UPDATE = 3'd3;
  localparam logic [2:0] REQ_LOAD   = 3'd4;

  localparam logic [2:0] ACT_RAMP     = 3'd0;
  localparam logic [2:0] ACT_GAUSSIAN = 3'd1;
  localparam logic [2:0] ACT_TANH     = 3'd2;
  localparam logic [2:0] ACT_LOGISTIC = 3'd3;
  localparam logic [2:0] ACT_SOFTPLUS = 3'd4;

  localparam logic [1:0] CFG_ACT_MODE = 2'd0;
  localparam logic [1:0] CFG_RATE     = 2'd1;
  localparam logic [1:0] CFG_MOMENTUM = 2'd2;

  localparam logic [2:0]  ACT_MODE_RESET = ACT_TANH;
  localparam logic [16:0] RATE_RESET     = 17'd9830;
  localparam logic [16:0] MOMENTUM_RESET = 17'd32768;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [5:0]         elem_index;
    logic signed [31:0] value;
    logic signed [31:0] weight;
    logic               last;
  } nbe_in_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] result_value;
  } nbe_out_t;

endpackage

`default_nettype wire

/* design/neuron_backprop_element.sv */
// Top level of the backpropagation neuron element with momentum.
`default_nettype none

// One neuron in Q16.16 with a 64-entry weight memory and a delta memory. A word
// is taken only when the block is idle. A forward or hidden element that is not
// the last of its run only adds its product to the accumulator.
// The last element and a target word run a sequencer over one shared 33 x 33
// multiplier and one radix-2 divider. Each exponential adds 14 Taylor terms to
// one and then scales by 1/e once for each whole unit of its argument (at most
// 31); the ramp mode and the softplus output need no exponential.
// A result waits in an output register until taken.
module neuron_backprop_element (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  nbe_pkg::nbe_in_t     in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output nbe_pkg::nbe_out_t    out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [16:0]     cfg_data
);
  import nbe_pkg::*;

  typedef enum logic [31:0] {
    S_IDLE    = 32'd1 << 0,
    S_FWD_MUL = 32'd1 << 1,
    S_HID_MUL = 32'd1 << 2,
    S_ACC     = 32'd1 << 3,
    S_CLOSE   = 32'd1 << 4,
    S_DISP    = 32'd1 << 5,
    S_HSQ     = 32'd1 << 6,
    S_GAU     = 32'd1 << 7,
    S_GAU2    = 32'd1 << 8,
    S_LOG     = 32'd1 << 9,
    S_LOG2    = 32'd1 << 10,
    S_TANH    = 32'd1 << 11,
    S_TANH2   = 32'd1 << 12,
    S_DTANH   = 32'd1 << 13,
    S_DLOG    = 32'd1 << 14,
    S_DLOG2   = 32'd1 << 15,
    S_DLOG3   = 32'd1 << 16,
    S_FV      = 32'd1 << 17,
    S_GFIN    = 32'd1 << 18,
    S_UPD1    = 32'd1 << 19,
    S_UPD2    = 32'd1 << 20,
    S_UPD3    = 32'd1 << 21,
    S_UPD4    = 32'd1 << 22,
    S_EXP0    = 32'd1 << 23,
    S_EXP_TM  = 32'd1 << 24,
    S_EXP_TD  = 32'd1 << 25,
    S_EXP_TA  = 32'd1 << 26,
    S_EXP_K   = 32'd1 << 27,
    S_EXP_K2  = 32'd1 << 28,
    S_MULW    = 32'd1 << 29,
    S_DIV     = 32'd1 << 30,
    S_EMIT    = 32'd1 << 31
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] rnd_frac(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v >>> (FRAC_BITS - 1)) + 64'sd1;
    return t >>> 1;
  endfunction

  function automatic logic signed [63:0] rnd_q30(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v >>> 29) + 64'sd1;
    return t >>> 1;
  endfunction

  function automatic logic signed [31:0] q30_to_q(input logic [31:0] t);
    logic [31:0] s;
    s = (t + (32'd1 << (Q30_DROP - 1))) >> Q30_DROP;
    return $signed(s);
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

  state_t state, mul_ret, div_ret, exp_ret;
  nbe_in_t item;
  logic    item_ok;
  logic    deriv;

  logic [2:0]  act_mode;
  logic [16:0] rate;
  logic [16:0] mom;

  logic signed [63:0] acc;
  logic signed [31:0] out_r;
  logic signed [31:0] grad;
  logic signed [31:0] x;
  logic signed [31:0] gx;
  logic signed [31:0] fv;
  logic               res_kind;
  logic signed [31:0] res_val;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;
  logic signed [63:0] prod;
  logic signed [31:0] prod_q;

  logic [MAG_W-1:0] mag;
  logic [29:0]      r;
  logic [30:0]      t;
  logic signed [32:0] s;
  logic signed [32:0] s_new;
  logic [30:0]      res;
  logic [30:0]      e;
  logic [3:0]       ic;
  logic [EXP_K_BITS-1:0] kc;

  logic [31:0] rem, dlo, den, quot;
  logic [4:0]  dcnt;
  logic [32:0] dtr;
  logic        dge;
  logic [63:0] div_num;
  logic [31:0] div_den;
  logic [31:0] den_e;

  logic [31:0] absx;
  logic signed [63:0] hsq;
  logic [31:0] q_p;

  logic signed [31:0] wmem [MAX_INPUTS];
  logic signed [31:0] dmem [MAX_INPUTS];
  logic [MAX_INPUTS-1:0] dvalid;
  logic signed [31:0] w_rd, d_rd;
  logic               dv_rd;
  logic signed [31:0] prevd;
  logic signed [31:0] nd;
  logic signed [31:0] w_new;

  logic              in_acc;
  logic              w_we;
  logic [ADDR_W-1:0] w_addr;
  logic signed [31:0] w_wd;
  logic              d_we;
  logic              idx_ok;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign idx_ok    = ({1'b0, in_data.elem_index} < 7'(MAX_INPUTS));

  assign mul_full = mul_a * mul_b;
  assign prod_q   = sat32(rnd_frac(prod));
  assign absx     = x[31] ? (~x + 32'd1) : x;
  assign hsq      = (prod + (64'sd1 <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
  assign den_e    = {1'b0, Q30_ONE} + {1'b0, e};
  assign prevd    = dv_rd ? d_rd : 32'sd0;
  assign nd       = sat32(64'(fv) + 64'(prod_q));
  assign w_new    = sat32(64'(w_rd) + 64'(nd));
  assign q_p      = x[31] ? ({1'b0, Q30_ONE} - quot) : quot;

  assign dtr   = {rem, dlo[31]};
  assign dge   = (dtr >= {1'b0, den});
  assign s_new = ic[0] ? (s - $signed({2'b00, quot[30:0]}))
                       : (s + $signed({2'b00, quot[30:0]}));

  always_comb begin
    div_num = 64'd0;
    div_den = den_e;
    case (state)
      S_EXP_TD: begin
        div_num = {34'd0, prod[59:30]};
        div_den = {28'd0, ic};
      end
      S_LOG: begin
        div_num = (64'd1 << 60) + {33'd0, den_e[31:1]};
      end
      S_TANH: begin
        div_num = ({33'd0, Q30_ONE - e} << 30) + {33'd0, den_e[31:1]};
      end
      S_DLOG: begin
        div_num = ({33'd0, e} << 30) + {33'd0, den_e[31:1]};
      end
      S_DLOG2: begin
        div_num = ({32'd0, quot} << 30) + {33'd0, den[31:1]};
        div_den = den;
      end
      default: begin
        div_num = 64'd0;
      end
    endcase
  end

  always_comb begin
    w_we   = 1'b0;
    d_we   = 1'b0;
    w_addr = in_data.elem_index[ADDR_W-1:0];
    w_wd   = in_data.weight;
    if (in_acc && in_data.req_type == REQ_LOAD && idx_ok) begin
      w_we = 1'b1;
    end else if (state == S_UPD4) begin
      w_we   = 1'b1;
      d_we   = 1'b1;
      w_addr = item.elem_index[ADDR_W-1:0];
      w_wd   = w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_addr] <= w_wd;
    end
    if (d_we) begin
      dmem[w_addr] <= nd;
    end
    if (in_acc) begin
      w_rd <= wmem[in_data.elem_index[ADDR_W-1:0]];
      d_rd <= dmem[in_data.elem_index[ADDR_W-1:0]];
      dv_rd <= dvalid[in_data.elem_index[ADDR_W-1:0]];
    end
    prod <= mul_full[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      acc       <= 64'sd0;
      out_r     <= 32'sd0;
      grad      <= 32'sd0;
      dvalid    <= '0;
      act_mode  <= ACT_MODE_RESET;
      rate      <= RATE_RESET;
      mom       <= MOMENTUM_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ACT_MODE: act_mode <= cfg_data[2:0];
          CFG_RATE:     rate <= cfg_data;
          CFG_MOMENTUM: mom <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      if (d_we) begin
        dvalid[w_addr] <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            item    <= in_data;
            item_ok <= idx_ok;
            case (in_data.req_type)
              REQ_FWD:    state <= S_FWD_MUL;
              REQ_HIDDEN: state <= S_HID_MUL;
              REQ_TARGET: begin
                gx    <= sat32(64'(in_data.value) - 64'(out_r));
                x     <= out_r;
                deriv <= 1'b1;
                state <= S_DISP;
              end
              REQ_UPDATE: state <= idx_ok ? S_UPD1 : S_IDLE;
              default:    state <= S_IDLE;
            endcase
          end
        end

        S_FWD_MUL: begin
          mul_a   <= 33'(item.value);
          mul_b   <= 33'(w_rd);
          mul_ret <= S_ACC;
          state   <= S_MULW;
        end

        S_HID_MUL: begin
          mul_a   <= 33'(item.value);
          mul_b   <= 33'(item.weight);
          mul_ret <= S_ACC;
          state   <= S_MULW;
        end

        S_ACC: begin
          if (item.req_type != REQ_FWD || item_ok) begin
            acc <= sat_add64(acc, prod);
          end
          state <= item.last ? S_CLOSE : S_IDLE;
        end

        S_CLOSE: begin
          acc <= 64'sd0;
          if (item.req_type == REQ_FWD) begin
            x     <= sat32(rnd_frac(acc));
            deriv <= 1'b0;
          end else begin
            gx    <= sat32(rnd_frac(acc));
            x     <= out_r;
            deriv <= 1'b1;
          end
          state <= S_DISP;
        end

        S_DISP: begin
          case (act_mode)
            ACT_RAMP: begin
              if (!deriv) begin
                fv <= (x < -ONE_Q) ? -ONE_Q : ((x > ONE_Q) ? ONE_Q : x);
              end else begin
                fv <= (x < -ONE_Q || x > ONE_Q) ? 32'sd0 : ONE_Q;
              end
              state <= S_FV;
            end
            ACT_SOFTPLUS: begin
              if (!deriv) begin
                fv    <= (x > 32'sd0) ? x : 32'sd0;
                state <= S_FV;
              end else begin
                mag     <= MAG_W'(absx);
                exp_ret <= S_LOG;
                state   <= S_EXP0;
              end
            end
            ACT_GAUSSIAN: begin
              mul_a   <= {1'b0, absx};
              mul_b   <= {1'b0, absx};
              mul_ret <= S_HSQ;
              state   <= S_MULW;
            end
            ACT_LOGISTIC: begin
              mag     <= MAG_W'(absx);
              exp_ret <= deriv ? S_DLOG : S_LOG;
              state   <= S_EXP0;
            end
            default: begin
              if (!deriv) begin
                mag     <= MAG_W'({absx, 1'b0});
                exp_ret <= S_TANH;
                state   <= S_EXP0;
              end else begin
                mul_a   <= 33'(x);
                mul_b   <= 33'(x);
                mul_ret <= S_DTANH;
                state   <= S_MULW;
              end
            end
          endcase
        end

        S_HSQ: begin
          mag     <= hsq[MAG_W-1:0];
          exp_ret <= S_GAU;
          state   <= S_EXP0;
        end

        S_GAU: begin
          if (!deriv) begin
            fv    <= q30_to_q({1'b0, e});
            state <= S_FV;
          end else begin
            mul_a   <= 33'(x);
            mul_b   <= {2'b00, e};
            mul_ret <= S_GAU2;
            state   <= S_MULW;
          end
        end

        S_GAU2: begin
          fv    <= sat32(rnd_q30(-prod));
          state <= S_FV;
        end

        S_LOG, S_TANH, S_DLOG, S_DLOG2: begin
          rem  <= div_num[63:32];
          dlo  <= div_num[31:0];
          den  <= div_den;
          dcnt <= 5'd0;
          case (state)
            S_LOG:   div_ret <= S_LOG2;
            S_TANH:  div_ret <= S_TANH2;
            S_DLOG:  div_ret <= S_DLOG2;
            default: div_ret <= S_DLOG3;
          endcase
          state <= S_DIV;
        end

        S_LOG2: begin
          fv    <= q30_to_q(q_p);
          state <= S_FV;
        end

        S_TANH2: begin
          fv    <= x[31] ? -q30_to_q(quot) : q30_to_q(quot);
          state <= S_FV;
        end

        S_DTANH: begin
          fv    <= sat32(64'(ONE_Q) - rnd_frac(prod));
          state <= S_FV;
        end

        S_DLOG3: begin
          fv    <= q30_to_q(quot);
          state <= S_FV;
        end

        S_FV: begin
          if (!deriv) begin
            out_r    <= fv;
            res_kind <= 1'b0;
            res_val  <= fv;
            state    <= S_EMIT;
          end else begin
            mul_a   <= 33'(gx);
            mul_b   <= 33'(fv);
            mul_ret <= S_GFIN;
            state   <= S_MULW;
          end
        end

        S_GFIN: begin
          grad     <= prod_q;
          res_kind <= 1'b1;
          res_val  <= prod_q;
          state    <= S_EMIT;
        end

        S_UPD1: begin
          mul_a   <= {16'd0, rate};
          mul_b   <= 33'(item.value);
          mul_ret <= S_UPD2;
          state   <= S_MULW;
        end

        S_UPD2: begin
          mul_a   <= 33'(prod_q);
          mul_b   <= 33'(grad);
          mul_ret <= S_UPD3;
          state   <= S_MULW;
        end

        S_UPD3: begin
          fv      <= prod_q;
          mul_a   <= {16'd0, mom};
          mul_b   <= 33'(prevd);
          mul_ret <= S_UPD4;
          state   <= S_MULW;
        end

        S_UPD4: begin
          state <= S_IDLE;
        end

        S_EXP0: begin
          if (|mag[MAG_W-1:FRAC_BITS+EXP_K_BITS]) begin
            e     <= 31'd0;
            state <= exp_ret;
          end else begin
            r     <= {mag[FRAC_BITS-1:0], {Q30_DROP{1'b0}}};
            t     <= Q30_ONE;
            s     <= 33'(Q30_ONE);
            ic    <= 4'd1;
            kc    <= mag[FRAC_BITS+EXP_K_BITS-1:FRAC_BITS];
            state <= S_EXP_TM;
          end
        end

        S_EXP_TM: begin
          mul_a   <= {2'b00, t};
          mul_b   <= {3'b000, r};
          mul_ret <= S_EXP_TD;
          state   <= S_MULW;
        end

        S_EXP_TD: begin
          rem     <= div_num[63:32];
          dlo     <= div_num[31:0];
          den     <= div_den;
          dcnt    <= 5'd0;
          div_ret <= S_EXP_TA;
          state   <= S_DIV;
        end

        S_EXP_TA: begin
          t  <= quot[30:0];
          s  <= s_new;
          ic <= ic + 4'd1;
          if (ic == 4'(TAYLOR_TERMS)) begin
            res   <= s_new[32] ? 31'd0 : s_new[30:0];
            state <= S_EXP_K;
          end else begin
            state <= S_EXP_TM;
          end
        end

        S_EXP_K: begin
          if (kc == '0) begin
            e     <= res;
            state <= exp_ret;
          end else begin
            mul_a   <= {2'b00, res};
            mul_b   <= {2'b00, E_INV_Q30};
            mul_ret <= S_EXP_K2;
            state   <= S_MULW;
          end
        end

        S_EXP_K2: begin
          res   <= 31'((prod + (64'sd1 <<< 29)) >>> 30);
          kc    <= kc - 1'b1;
          state <= S_EXP_K;
        end

        S_MULW: begin
          state <= mul_ret;
        end

        S_DIV: begin
          rem  <= dge ? 32'(dtr - {1'b0, den}) : dtr[31:0];
          dlo  <= {dlo[30:0], 1'b0};
          quot <= {quot[30:0], dge};
          dcnt <= dcnt + 5'd1;
          if (&dcnt) begin
            state <= div_ret;
          end
        end

        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid             <= 1'b1;
            out_data.result_kind  <= res_kind;
            out_data.result_value <= res_val;
            state                 <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
